>>> rtl/mauv_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mauv_pkg
// Shared types and constants for the molecule axis unit vector block.
// ----------------------------------------------------------------------------
package mauv_pkg;

   localparam int COORD_W = 32;                // position width, Q15.16
   localparam int D_W     = COORD_W + 2;       // doubled axis component, signed
   localparam int MAG_W   = D_W - 1;           // magnitude of a doubled component
   localparam int E_W     = 30;                // normalised magnitude, top bit at 29
   localparam int E_TOP   = E_W - 1;
   localparam int POS_W   = 6;                 // holds bit positions of MAG_W
   localparam int SQ_W    = 2 * E_W;           // one square
   localparam int SUM_W   = SQ_W + 2;          // sum of three squares
   localparam int ROOT_W  = SUM_W / 2;         // floor square root
   localparam int UNIT_W  = 16;

   localparam logic KIND_MIDPOINT = 1'b0;
   localparam logic KIND_BOND     = 1'b1;

   typedef struct packed {
      logic                      molecule_kind;
      logic signed [COORD_W-1:0] first_x;
      logic signed [COORD_W-1:0] first_y;
      logic signed [COORD_W-1:0] first_z;
      logic signed [COORD_W-1:0] second_x;
      logic signed [COORD_W-1:0] second_y;
      logic signed [COORD_W-1:0] second_z;
      logic signed [COORD_W-1:0] third_x;
      logic signed [COORD_W-1:0] third_y;
      logic signed [COORD_W-1:0] third_z;
      logic                      is_origin_step;
   } req_type;

   typedef struct packed {
      logic signed [UNIT_W-1:0] unit_x;
      logic signed [UNIT_W-1:0] unit_y;
      logic signed [UNIT_W-1:0] unit_z;
      logic                     record_as_initial;
      logic                     zero_length;
   } rsp_type;

   typedef struct packed {
      logic [2:0] neg;
      logic       zero;
      logic       origin;
   } flags_type;

   typedef struct packed {
      logic [2:0][E_W-1:0] e;
      flags_type           flags;
   } sqrt_side_type;

endpackage

>>> rtl/molecule_axis_unit_vector.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// molecule_axis_unit_vector
// Unit dipole axis of a three-atom molecule, signed Q0.15, saturated.
// ----------------------------------------------------------------------------
// One word in, one word out, a new word accepted every cycle unless the
// output stalls. The path is five front stages (axis, maximum, normalise,
// square, sum), a chain of 31 square root cells giving one root bit each, a
// chain of UNIT_FRAC_BITS + 1 divider cells giving one quotient bit per cell
// for all three components, and the output register. Stalls ripple back
// through per-cell valid bits, so bubbles close up. A zero axis gives zero
// components with zero_length set.
module molecule_axis_unit_vector #(
   parameter int UNIT_FRAC_BITS = 15
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  mauv_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output mauv_pkg::rsp_type rsp_data
);

   localparam int NUM_W  = mauv_pkg::E_W + UNIT_FRAC_BITS + 1;
   localparam int QUO_W  = UNIT_FRAC_BITS + 1;
   localparam int NSQ    = mauv_pkg::ROOT_W;
   localparam int NDIV   = UNIT_FRAC_BITS + 1;
   localparam int CMP_W  = QUO_W + mauv_pkg::UNIT_W;

   // ---------------- stage 1: doubled axis, sign and magnitude ----------------
   logic                                   s1_v_ff, s1_rdy;
   logic [2:0][mauv_pkg::MAG_W-1:0]        s1_mag_ff, s1_mag_in;
   mauv_pkg::flags_type                    s1_flags_ff, s1_flags_in;
   logic signed [mauv_pkg::D_W-1:0]        d [3];
   logic signed [mauv_pkg::D_W-1:0]        a [3], b [3], c [3];

   always_comb begin
      a[0] = mauv_pkg::D_W'(req_data.first_x);
      a[1] = mauv_pkg::D_W'(req_data.first_y);
      a[2] = mauv_pkg::D_W'(req_data.first_z);
      b[0] = mauv_pkg::D_W'(req_data.second_x);
      b[1] = mauv_pkg::D_W'(req_data.second_y);
      b[2] = mauv_pkg::D_W'(req_data.second_z);
      c[0] = mauv_pkg::D_W'(req_data.third_x);
      c[1] = mauv_pkg::D_W'(req_data.third_y);
      c[2] = mauv_pkg::D_W'(req_data.third_z);
      s1_flags_in.zero   = 1'b1;
      s1_flags_in.origin = req_data.is_origin_step;
      for (int i = 0; i < 3; i++) begin
         if (req_data.molecule_kind == mauv_pkg::KIND_BOND) begin
            d[i] = (b[i] - c[i]) <<< 1;
         end else begin
            d[i] = a[i] + b[i] - (c[i] <<< 1);
         end
         s1_flags_in.neg[i] = d[i][mauv_pkg::D_W-1];
         s1_mag_in[i] = d[i][mauv_pkg::D_W-1] ? mauv_pkg::MAG_W'(-d[i])
                                              : mauv_pkg::MAG_W'(d[i]);
         if (d[i] != '0) begin
            s1_flags_in.zero = 1'b0;
         end
      end
   end

   // ---------------- stage 2: largest magnitude ----------------
   logic                                   s2_v_ff, s2_rdy;
   logic [2:0][mauv_pkg::MAG_W-1:0]        s2_mag_ff;
   logic [mauv_pkg::MAG_W-1:0]             s2_max_ff, s2_max_in;
   mauv_pkg::flags_type                    s2_flags_ff;

   always_comb begin
      s2_max_in = s1_mag_ff[0];
      if (s1_mag_ff[1] > s2_max_in) s2_max_in = s1_mag_ff[1];
      if (s1_mag_ff[2] > s2_max_in) s2_max_in = s1_mag_ff[2];
   end

   // ---------------- stage 3: normalise top bit to E_TOP ----------------
   logic                                   s3_v_ff, s3_rdy;
   logic [2:0][mauv_pkg::E_W-1:0]          s3_e_ff, s3_e_in;
   mauv_pkg::flags_type                    s3_flags_ff;
   logic [mauv_pkg::POS_W-1:0]             top_pos;

   always_comb begin
      top_pos = '0;
      for (int i = 0; i < mauv_pkg::MAG_W; i++) begin
         if (s2_max_ff[i]) top_pos = mauv_pkg::POS_W'(i);
      end
      for (int i = 0; i < 3; i++) begin
         if (top_pos > mauv_pkg::POS_W'(mauv_pkg::E_TOP)) begin
            s3_e_in[i] = mauv_pkg::E_W'(s2_mag_ff[i]
                         >> (top_pos - mauv_pkg::POS_W'(mauv_pkg::E_TOP)));
         end else begin
            s3_e_in[i] = mauv_pkg::E_W'(s2_mag_ff[i]
                         << (mauv_pkg::POS_W'(mauv_pkg::E_TOP) - top_pos));
         end
      end
   end

   // ---------------- stage 4: squares ----------------
   logic                                   s4_v_ff, s4_rdy;
   logic [2:0][mauv_pkg::SQ_W-1:0]         s4_sq_ff;
   logic [2:0][mauv_pkg::E_W-1:0]          s4_e_ff;
   mauv_pkg::flags_type                    s4_flags_ff;

   // ---------------- stage 5: sum of squares ----------------
   logic                                   s5_v_ff, s5_rdy;
   logic [mauv_pkg::SUM_W-1:0]             s5_sum_ff;
   logic [2:0][mauv_pkg::E_W-1:0]          s5_e_ff;
   mauv_pkg::flags_type                    s5_flags_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
         s3_v_ff <= 1'b0;
         s4_v_ff <= 1'b0;
         s5_v_ff <= 1'b0;
      end else begin
         if (s1_rdy) s1_v_ff <= req_valid;
         if (s2_rdy) s2_v_ff <= s1_v_ff;
         if (s3_rdy) s3_v_ff <= s2_v_ff;
         if (s4_rdy) s4_v_ff <= s3_v_ff;
         if (s5_rdy) s5_v_ff <= s4_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_rdy) begin
         s1_mag_ff   <= s1_mag_in;
         s1_flags_ff <= s1_flags_in;
      end
      if (s2_rdy) begin
         s2_mag_ff   <= s1_mag_ff;
         s2_max_ff   <= s2_max_in;
         s2_flags_ff <= s1_flags_ff;
      end
      if (s3_rdy) begin
         s3_e_ff     <= s3_e_in;
         s3_flags_ff <= s2_flags_ff;
      end
      if (s4_rdy) begin
         for (int i = 0; i < 3; i++) begin
            s4_sq_ff[i] <= mauv_pkg::SQ_W'(s3_e_ff[i]) * mauv_pkg::SQ_W'(s3_e_ff[i]);
         end
         s4_e_ff     <= s3_e_ff;
         s4_flags_ff <= s3_flags_ff;
      end
      if (s5_rdy) begin
         s5_sum_ff   <= mauv_pkg::SUM_W'(s4_sq_ff[0]) + mauv_pkg::SUM_W'(s4_sq_ff[1])
                      + mauv_pkg::SUM_W'(s4_sq_ff[2]);
         s5_e_ff     <= s4_e_ff;
         s5_flags_ff <= s4_flags_ff;
      end
   end

   // ---------------- square root chain ----------------
   logic                               sq_v    [NSQ+1];
   logic                               sq_rdy  [NSQ+1];
   logic [mauv_pkg::SUM_W-1:0]         sq_rem  [NSQ+1];
   logic [mauv_pkg::ROOT_W-1:0]        sq_root [NSQ+1];
   mauv_pkg::sqrt_side_type            sq_side [NSQ+1];

   assign sq_v[0]          = s5_v_ff;
   assign sq_rem[0]        = s5_sum_ff;
   assign sq_root[0]       = '0;
   assign sq_side[0].e     = s5_e_ff;
   assign sq_side[0].flags = s5_flags_ff;

   for (genvar k = 0; k < NSQ; k++) begin : g_sqrt
      mauv_sqrt_cell #(.STEP(NSQ - 1 - k)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (sq_v[k]),
         .in_ready  (sq_rdy[k]),
         .in_rem    (sq_rem[k]),
         .in_root   (sq_root[k]),
         .in_side   (sq_side[k]),
         .out_valid (sq_v[k+1]),
         .out_ready (sq_rdy[k+1]),
         .out_rem   (sq_rem[k+1]),
         .out_root  (sq_root[k+1]),
         .out_side  (sq_side[k+1])
      );
   end

   // ---------------- divider chain ----------------
   logic                               dv_v     [NDIV+1];
   logic                               dv_rdy   [NDIV+1];
   logic [2:0][NUM_W-1:0]              dv_rem   [NDIV+1];
   logic [2:0][QUO_W-1:0]              dv_quo   [NDIV+1];
   logic [mauv_pkg::ROOT_W-1:0]        dv_div   [NDIV+1];
   mauv_pkg::flags_type                dv_flags [NDIV+1];

   // numerator rounds to nearest: E * 2^F + floor(R / 2)
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         dv_rem[0][i] = (NUM_W'(sq_side[NSQ].e[i]) << UNIT_FRAC_BITS)
                      + NUM_W'(sq_root[NSQ] >> 1);
         dv_quo[0][i] = '0;
      end
   end

   assign dv_v[0]     = sq_v[NSQ];
   assign sq_rdy[NSQ] = dv_rdy[0];
   assign dv_div[0]   = sq_root[NSQ];
   assign dv_flags[0] = sq_side[NSQ].flags;

   for (genvar k = 0; k < NDIV; k++) begin : g_div
      mauv_div_cell #(.NUM_W(NUM_W), .QUO_W(QUO_W), .STEP(NDIV - 1 - k)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (dv_v[k]),
         .in_ready  (dv_rdy[k]),
         .in_rem    (dv_rem[k]),
         .in_quo    (dv_quo[k]),
         .in_div    (dv_div[k]),
         .in_flags  (dv_flags[k]),
         .out_valid (dv_v[k+1]),
         .out_ready (dv_rdy[k+1]),
         .out_rem   (dv_rem[k+1]),
         .out_quo   (dv_quo[k+1]),
         .out_div   (dv_div[k+1]),
         .out_flags (dv_flags[k+1])
      );
   end

   // ---------------- sign, saturation, output register ----------------
   logic                               out_v_ff;
   mauv_pkg::rsp_type                  out_ff, out_in;
   logic [2:0][mauv_pkg::UNIT_W-1:0]   unit;
   logic [CMP_W-1:0]                   q_ext;
   mauv_pkg::flags_type                fl;

   always_comb begin
      fl = dv_flags[NDIV];
      for (int i = 0; i < 3; i++) begin
         q_ext = CMP_W'(dv_quo[NDIV][i]);
         if (fl.zero) begin
            unit[i] = '0;
         end else if (fl.neg[i]) begin
            if (q_ext > (CMP_W'(1) << (mauv_pkg::UNIT_W - 1))) begin
               unit[i] = {1'b1, {(mauv_pkg::UNIT_W-1){1'b0}}};
            end else begin
               unit[i] = mauv_pkg::UNIT_W'(-q_ext);
            end
         end else if (q_ext > ((CMP_W'(1) << (mauv_pkg::UNIT_W - 1)) - CMP_W'(1))) begin
            unit[i] = {1'b0, {(mauv_pkg::UNIT_W-1){1'b1}}};
         end else begin
            unit[i] = mauv_pkg::UNIT_W'(q_ext);
         end
      end
      out_in.unit_x            = unit[0];
      out_in.unit_y            = unit[1];
      out_in.unit_z            = unit[2];
      out_in.record_as_initial = fl.origin;
      out_in.zero_length       = fl.zero;
   end

   assign dv_rdy[NDIV] = !out_v_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else if (dv_rdy[NDIV]) begin
         out_v_ff <= dv_v[NDIV];
      end
   end

   always_ff @(posedge clock) begin
      if (dv_rdy[NDIV]) begin
         out_ff <= out_in;
      end
   end

   // stage ready ripples back from the first cell of the root chain
   assign s5_rdy    = !s5_v_ff || sq_rdy[0];
   assign s4_rdy    = !s4_v_ff || s5_rdy;
   assign s3_rdy    = !s3_v_ff || s4_rdy;
   assign s2_rdy    = !s2_v_ff || s3_rdy;
   assign s1_rdy    = !s1_v_ff || s2_rdy;
   assign req_ready = s1_rdy;

   assign rsp_valid = out_v_ff;
   assign rsp_data  = out_ff;

   // ---------------- checks ----------------
   a_zero_gives_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.zero_length |->
         rsp_data.unit_x == '0 && rsp_data.unit_y == '0 && rsp_data.unit_z == '0)
      else $error("zero axis with nonzero components");

   a_nonzero_axis: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.zero_length |->
         rsp_data.unit_x != '0 || rsp_data.unit_y != '0 || rsp_data.unit_z != '0)
      else $error("nonzero axis gave all-zero unit vector");

   a_stall_only_on_output: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("input stalled while output free");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result word present after reset");

endmodule

>>> rtl/mauv_sqrt_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mauv_sqrt_cell
// One root bit of the square root chain: trial subtract, register, hand on.
// ----------------------------------------------------------------------------
module mauv_sqrt_cell #(
   parameter int STEP = 0
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              in_valid,
   output logic                              in_ready,
   input  logic [mauv_pkg::SUM_W-1:0]        in_rem,
   input  logic [mauv_pkg::ROOT_W-1:0]       in_root,
   input  mauv_pkg::sqrt_side_type           in_side,
   output logic                              out_valid,
   input  logic                              out_ready,
   output logic [mauv_pkg::SUM_W-1:0]        out_rem,
   output logic [mauv_pkg::ROOT_W-1:0]       out_root,
   output mauv_pkg::sqrt_side_type           out_side
);

   logic                          valid_ff;
   logic [mauv_pkg::SUM_W-1:0]    rem_ff,  rem_in;
   logic [mauv_pkg::ROOT_W-1:0]   root_ff, root_in;
   mauv_pkg::sqrt_side_type       side_ff;
   logic [mauv_pkg::SUM_W-1:0]    trial;

   assign in_ready = !valid_ff || out_ready;

   // remainder holds S - root^2; trial is (2*root + 2^STEP) * 2^STEP
   always_comb begin
      trial   = (mauv_pkg::SUM_W'(in_root) << (STEP + 1))
              | (mauv_pkg::SUM_W'(1) << (2 * STEP));
      rem_in  = in_rem;
      root_in = in_root;
      if (in_rem >= trial) begin
         rem_in  = in_rem - trial;
         root_in = in_root | (mauv_pkg::ROOT_W'(1) << STEP);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) begin
         rem_ff  <= rem_in;
         root_ff <= root_in;
         side_ff <= in_side;
      end
   end

   assign out_valid = valid_ff;
   assign out_rem   = rem_ff;
   assign out_root  = root_ff;
   assign out_side  = side_ff;

endmodule

>>> rtl/mauv_div_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mauv_div_cell
// One quotient bit for all three lanes of the restoring divider chain.
// ----------------------------------------------------------------------------
module mauv_div_cell #(
   parameter int NUM_W = 46,
   parameter int QUO_W = 16,
   parameter int STEP  = 0
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              in_valid,
   output logic                              in_ready,
   input  logic [2:0][NUM_W-1:0]             in_rem,
   input  logic [2:0][QUO_W-1:0]             in_quo,
   input  logic [mauv_pkg::ROOT_W-1:0]       in_div,
   input  mauv_pkg::flags_type               in_flags,
   output logic                              out_valid,
   input  logic                              out_ready,
   output logic [2:0][NUM_W-1:0]             out_rem,
   output logic [2:0][QUO_W-1:0]             out_quo,
   output logic [mauv_pkg::ROOT_W-1:0]       out_div,
   output mauv_pkg::flags_type               out_flags
);

   logic                          valid_ff;
   logic [2:0][NUM_W-1:0]         rem_ff, rem_in;
   logic [2:0][QUO_W-1:0]         quo_ff, quo_in;
   logic [mauv_pkg::ROOT_W-1:0]   div_ff;
   mauv_pkg::flags_type           flags_ff;
   logic [NUM_W-1:0]              shifted;

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      shifted = NUM_W'(in_div) << STEP;
      for (int i = 0; i < 3; i++) begin
         rem_in[i] = in_rem[i];
         quo_in[i] = in_quo[i];
         if (in_rem[i] >= shifted) begin
            rem_in[i] = in_rem[i] - shifted;
            quo_in[i] = in_quo[i] | (QUO_W'(1) << STEP);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) begin
         rem_ff   <= rem_in;
         quo_ff   <= quo_in;
         div_ff   <= in_div;
         flags_ff <= in_flags;
      end
   end

   assign out_valid = valid_ff;
   assign out_rem   = rem_ff;
   assign out_quo   = quo_ff;
   assign out_div   = div_ff;
   assign out_flags = flags_ff;

endmodule

>>> sim/mauv_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mauv_checker
// Predicts the unit axis of each accepted request and compares the response.
// ----------------------------------------------------------------------------
module mauv_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_ready,
   input  mauv_pkg::req_type req_data,
   input  logic              rsp_valid,
   input  logic              rsp_ready,
   input  mauv_pkg::rsp_type rsp_data,
   output int                fail_count,
   output int                pending
);

   localparam int FRAC = 15;

   mauv_pkg::rsp_type axis_q[$];

   function automatic logic [63:0] root_floor(input logic [63:0] v);
      logic [63:0] r;
      logic [63:0] b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function automatic mauv_pkg::rsp_type unit_axis(input mauv_pkg::req_type w);
      mauv_pkg::rsp_type  o;
      logic signed [63:0] a [3];
      logic signed [63:0] b [3];
      logic signed [63:0] c [3];
      logic signed [63:0] d;
      logic [63:0]        m [3];
      logic               n [3];
      logic [63:0]        top;
      logic [63:0]        s;
      logic [63:0]        r;
      logic [63:0]        q;
      logic signed [63:0] v;
      a[0] = w.first_x;  a[1] = w.first_y;  a[2] = w.first_z;
      b[0] = w.second_x; b[1] = w.second_y; b[2] = w.second_z;
      c[0] = w.third_x;  c[1] = w.third_y;  c[2] = w.third_z;
      top = 0;
      for (int i = 0; i < 3; i++) begin
         if (w.molecule_kind == mauv_pkg::KIND_BOND) d = 2 * (b[i] - c[i]);
         else d = a[i] + b[i] - 2 * c[i];
         n[i] = d < 0;
         m[i] = n[i] ? -d : d;
         if (m[i] > top) top = m[i];
      end
      o = '0;
      o.record_as_initial = w.is_origin_step;
      if (top == 0) begin
         o.zero_length = 1'b1;
         return o;
      end
      while (top >= (64'd1 << 30)) begin
         top = top >> 1;
         for (int i = 0; i < 3; i++) m[i] = m[i] >> 1;
      end
      while (top < (64'd1 << 29)) begin
         top = top << 1;
         for (int i = 0; i < 3; i++) m[i] = m[i] << 1;
      end
      s = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
      r = root_floor(s);
      for (int i = 0; i < 3; i++) begin
         q = ((m[i] << FRAC) + (r >> 1)) / r;
         if (n[i]) v = (q > 32768) ? -64'sd32768 : -$signed(q);
         else v = (q > 32767) ? 64'sd32767 : $signed(q);
         case (i)
            0: o.unit_x = v[15:0];
            1: o.unit_y = v[15:0];
            default: o.unit_z = v[15:0];
         endcase
      end
      return o;
   endfunction

   assign pending = axis_q.size();

   always @(posedge clock) begin
      mauv_pkg::rsp_type e;
      if (reset) begin
         fail_count <= 0;
         axis_q.delete();
      end else begin
         if (req_valid && req_ready) axis_q.push_back(unit_axis(req_data));
         if (rsp_valid && rsp_ready) begin
            if (axis_q.size() == 0) begin
               $display("%0t: unexpected word %h", $time, rsp_data);
               fail_count <= fail_count + 1;
            end else begin
               e = axis_q.pop_front();
               if (e.unit_x !== rsp_data.unit_x || e.unit_y !== rsp_data.unit_y ||
                   e.unit_z !== rsp_data.unit_z ||
                   e.record_as_initial !== rsp_data.record_as_initial ||
                   e.zero_length !== rsp_data.zero_length) begin
                  $display("%0t: mismatch expected %h actual %h", $time, e, rsp_data);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end
endmodule

>>> sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives directed and random molecules into the unit axis block.
// ----------------------------------------------------------------------------
module tb;

   localparam int N_RANDOM = 540;
   localparam int WATCHDOG = 5000;

   logic              clock = 0;
   logic              reset = 1;
   logic              req_valid = 0;
   logic              req_ready;
   mauv_pkg::req_type req_data = '0;
   logic              rsp_valid;
   logic              rsp_ready = 0;
   mauv_pkg::rsp_type rsp_data;
   int                fail_count;
   int                pending;
   int                quiet;
   bit                calm = 0;
   bit                done = 0;

   always begin
      #4 clock = 1;
      #4 clock = 0;
   end

   molecule_axis_unit_vector dut (.*);

   mauv_checker chk (.*);

   always @(posedge clock) begin
      if (reset) rsp_ready <= 0;
      else rsp_ready <= calm || ($urandom_range(99) >= 11);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet <= 0;
      else quiet <= quiet + 1;
      if (quiet > WATCHDOG && !done) begin
         $display("FAILURE");
         $finish;
      end
   end

   function automatic logic signed [31:0] pick_coord(input int style);
      case (style)
         0: return $urandom;
         1: return $signed(32'($urandom_range(2000))) - 1000;
         2: return $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
         default: return $signed($urandom_range(65535) << 8) - (32'sd1 << 23);
      endcase
   endfunction

   task automatic send(input mauv_pkg::req_type w);
      req_valid <= 1;
      req_data  <= w;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic send_gap(input mauv_pkg::req_type w);
      while (!calm && $urandom_range(99) < 11) begin
         req_valid <= 0;
         @(posedge clock);
      end
      send(w);
   endtask

   function automatic mauv_pkg::req_type rand_word();
      mauv_pkg::req_type w;
      int                st;
      st = $urandom_range(3);
      w.molecule_kind  = 1'($urandom);
      w.first_x  = pick_coord(st); w.first_y  = pick_coord(st);
      w.first_z  = pick_coord(st); w.second_x = pick_coord(st);
      w.second_y = pick_coord(st); w.second_z = pick_coord(st);
      w.third_x  = pick_coord(st); w.third_y  = pick_coord(st);
      w.third_z  = pick_coord(st);
      w.is_origin_step = 1'($urandom);
      if ($urandom_range(9) == 0) begin
         // degenerate: third atom placed on the axis origin
         w.third_x = w.second_x; w.third_y = w.second_y; w.third_z = w.second_z;
         if (!w.molecule_kind) begin
            w.first_x = w.second_x; w.first_y = w.second_y; w.first_z = w.second_z;
         end
      end
      return w;
   endfunction

   initial begin
      mauv_pkg::req_type w;
      repeat (6) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // directed: extremes, zero axis, unit along each axis, midpoint z
      for (int k = 0; k < 20; k++) begin
         w = '0;
         w.molecule_kind  = k[0];
         w.is_origin_step = k[1];
         case (k / 2)
            0: ;
            1: begin w.second_x = 32'h00010000; w.first_x = 32'h00010000; end
            2: begin w.second_y = 32'h80000000; w.first_y = 32'h80000000; end
            3: begin w.second_z = 32'h7fffffff; w.first_z = 32'h7fffffff;
                     w.third_z = 32'h80000000; end
            4: begin w.first_x = 32'h7fffffff; w.second_x = 32'h7fffffff;
                     w.first_y = 32'h7fffffff; w.second_y = 32'h7fffffff;
                     w.first_z = 32'h7fffffff; w.second_z = 32'h7fffffff;
                     w.third_x = 32'h80000000; w.third_y = 32'h80000000;
                     w.third_z = 32'h80000000; end
            5: begin w.first_z = 32'h00050000; w.first_y = 32'h7fff0000;
                     w.second_y = 32'h80000000; end
            6: begin w.second_x = 1; w.first_x = 1; end
            7: begin w.third_x = 32'h80000000; w.third_y = 32'h7fffffff;
                     w.third_z = 32'h80000000; end
            8: begin w.first_x = 32'h00030000; w.first_y = 32'h00040000;
                     w.second_x = 32'h00030000; w.second_y = 32'h00040000; end
            default: begin w.first_x = 32'hffffffff; w.third_x = 32'hffffffff; end
         endcase
         send_gap(w);
      end
      // hold off until the pipe has drained
      req_valid <= 0;
      while (pending != 0) @(posedge clock);
      for (int k = 0; k < N_RANDOM; k++) begin
         calm = (k >= 200 && k < 300);
         send_gap(rand_word());
      end
      req_valid <= 0;
      calm = 0;
      while (pending != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      done = 1;
      if (fail_count == 0) $display("SUCCESS");
      else $display("FAILURE");
      $finish;
   end
endmodule
